### hdl/snappy_stream_decompressor_top_assert.svh
// Assertion macros for the decompressor RTL.
`ifndef SNAPPY_STREAM_DECOMPRESSOR_TOP_ASSERT_SVH
`define SNAPPY_STREAM_DECOMPRESSOR_TOP_ASSERT_SVH

// Condition a must bring condition c in the same cycle.
`define SNPD_ASSERT_SAME(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("snpd assertion failed");

// Condition a must bring condition c in the next cycle.
`define SNPD_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("snpd assertion failed");

`endif

### hdl/snpd_pkg.sv
`timescale 1ns / 1ps

package snpd_pkg;

    // Default history window in bytes.
    localparam int unsigned WINDOW_BYTES_DEF = 65536;

    // Element kinds held in the low two bits of a tag.
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_COPY1   = 2'd1;
    localparam logic [1:0] KIND_COPY2   = 2'd2;
    localparam logic [1:0] KIND_COPY4   = 2'd3;

    // Inline literal length codes from this value upwards mean extra length bytes.
    localparam logic [5:0] LIT_EXT_FIRST = 6'd60;

    // Top-level sequencer states.
    typedef enum logic [3:0] {
        S_PARSE    = 4'b0001,
        S_COPY_CHK = 4'b0010,
        S_COPY_RD  = 4'b0100,
        S_COPY_WR  = 4'b1000
    } t_state;

    // Parser phases within the element stream.
    typedef enum logic [3:0] {
        PH_TAG     = 4'b0001,
        PH_LITLEN  = 4'b0010,
        PH_LITDATA = 4'b0100,
        PH_COPYOFF = 4'b1000
    } t_phase;

    // Number of length or offset bytes that follow a tag.
    function automatic logic [2:0] field_total(input logic [7:0] tag);
        logic [2:0] total;
        total = 3'd0;
        case (tag[1:0])
            KIND_LITERAL: begin
                if (tag[7:2] >= LIT_EXT_FIRST) begin
                    total = 3'(tag[7:2] - 6'd59);
                end
            end
            KIND_COPY1: total = 3'd1;
            KIND_COPY2: total = 3'd2;
            default:    total = 3'd4;
        endcase
        return total;
    endfunction

endpackage

### hdl/snpd_ram.sv
`timescale 1ns / 1ps

module snpd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/snappy_stream_decompressor_top.sv
`timescale 1ns / 1ps

// Snappy element-stream decompressor. Feed it the compressed stream one byte
// per item, starting after the length preamble, and write the expected
// decompressed length to the configuration port first. Tag, length, offset
// and literal bytes are taken at one item per cycle, literal bytes only while
// the output register can take a result; a literal byte gives one result item.
// After the last offset byte of a copy the offset is checked, and then each
// copied byte (1 to 64 bytes) is read from the history ring through its registered
// read port and written back before the next one is read; input waits meanwhile.
// A bad offset gives a single error item after the check. Once the configured
// length has been reached, further input items are accepted and dropped.
module snappy_stream_decompressor_top #(
    parameter int unsigned WINDOW_BYTES = snpd_pkg::WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_output_length,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_stream_done,
    output logic        o_bad_offset
);

    `include "snappy_stream_decompressor_top_assert.svh"

    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    // Sequencer and parser state.
    snpd_pkg::t_state r_state, n_state;
    snpd_pkg::t_phase r_phase, n_phase;
    logic [31:0]      r_out_len;
    logic [AW-1:0]    r_wp, n_wp;
    logic [31:0]      r_bw, n_bw;
    logic [7:0]       r_tag, n_tag;
    logic [31:0]      r_acc, n_acc;
    logic [2:0]       r_left, n_left;
    logic [32:0]      r_lit_rem, n_lit_rem;
    logic [6:0]       r_copy_left, n_copy_left;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;
    logic             r_out_done, n_out_done;
    logic             r_out_bad, n_out_bad;

    // History ring ports.
    logic             ram_wr_en;
    logic [AW-1:0]    ram_rd_addr;
    logic [7:0]       ram_wr_data;
    logic [7:0]       ram_rd_data;

    // Combinational helpers.
    logic             out_free;
    logic             in_acc;
    logic             complete;
    logic [AW-1:0]    wp_inc;
    logic [31:0]      offset;
    logic [6:0]       copy_len;
    logic [31:0]      room;
    logic             off_bad;
    logic [AW:0]      src_sum;
    logic [31:0]      acc_new;
    logic [1:0]       pos;
    logic             bw_hits_len;

    snpd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Handshakes.
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == snpd_pkg::S_PARSE) &&
                         ((r_phase != snpd_pkg::PH_LITDATA) || out_free);
    assign in_acc      = i_in_valid && o_in_ready;
    assign complete    = (r_bw >= r_out_len);
    assign bw_hits_len = ((r_bw + 32'd1) == r_out_len);

    // Ring pointer with wrap at the window size.
    assign wp_inc = (r_wp == AW'(WINDOW_BYTES - 1)) ? '0 : r_wp + AW'(1);

    // Copy source: write pointer minus offset, modulo the window.
    always_comb begin
        src_sum = {1'b0, r_wp} + (AW + 1)'(WINDOW_BYTES) - offset[AW:0];
        if (src_sum >= (AW + 1)'(WINDOW_BYTES)) begin
            src_sum = src_sum - (AW + 1)'(WINDOW_BYTES);
        end
        ram_rd_addr = src_sum[AW-1:0];
    end

    // Offset, length and checks for the held copy tag.
    always_comb begin
        if (r_tag[1:0] == snpd_pkg::KIND_COPY1) begin
            offset   = {21'd0, r_tag[7:5], r_acc[7:0]};
            copy_len = 7'(r_tag[4:2]) + 7'd4;
        end else begin
            offset   = r_acc;
            copy_len = 7'(r_tag[7:2]) + 7'd1;
        end
        room    = r_out_len - r_bw;
        off_bad = (offset == 32'd0) || (offset > r_bw) || (offset > 32'(WINDOW_BYTES));
    end

    // Field byte merged into the accumulator, least significant first.
    always_comb begin
        pos     = 2'(snpd_pkg::field_total(r_tag) - r_left);
        acc_new = r_acc;
        case (pos)
            2'd0:    acc_new[7:0]   = i_in_byte;
            2'd1:    acc_new[15:8]  = i_in_byte;
            2'd2:    acc_new[23:16] = i_in_byte;
            default: acc_new[31:24] = i_in_byte;
        endcase
    end

    // Next-state logic for the parser, the copy engine and the output register.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_bw        = r_bw;
        n_tag       = r_tag;
        n_acc       = r_acc;
        n_left      = r_left;
        n_lit_rem   = r_lit_rem;
        n_copy_left = r_copy_left;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        n_out_bad   = r_out_bad;
        ram_wr_en   = 1'b0;
        ram_wr_data = i_in_byte;

        unique case (r_state)
            snpd_pkg::S_PARSE: begin
                if (in_acc && !complete) begin
                    unique case (r_phase)
                        snpd_pkg::PH_TAG: begin
                            n_tag  = i_in_byte;
                            n_acc  = '0;
                            n_left = snpd_pkg::field_total(i_in_byte);
                            if (i_in_byte[1:0] != snpd_pkg::KIND_LITERAL) begin
                                n_phase = snpd_pkg::PH_COPYOFF;
                            end else if (n_left == 3'd0) begin
                                n_lit_rem = 33'(i_in_byte[7:2]) + 33'd1;
                                n_phase   = snpd_pkg::PH_LITDATA;
                            end else begin
                                n_phase = snpd_pkg::PH_LITLEN;
                            end
                        end
                        snpd_pkg::PH_LITLEN: begin
                            n_acc  = acc_new;
                            n_left = r_left - 3'd1;
                            if (r_left == 3'd1) begin
                                n_lit_rem = {1'b0, acc_new} + 33'd1;
                                n_phase   = snpd_pkg::PH_LITDATA;
                            end
                        end
                        snpd_pkg::PH_LITDATA: begin
                            ram_wr_en   = 1'b1;
                            n_wp        = wp_inc;
                            n_bw        = r_bw + 32'd1;
                            n_lit_rem   = r_lit_rem - 33'd1;
                            n_out_valid = 1'b1;
                            n_out_byte  = i_in_byte;
                            n_out_last  = 1'b1;
                            n_out_done  = bw_hits_len;
                            n_out_bad   = 1'b0;
                            if (r_lit_rem == 33'd1) begin
                                n_phase = snpd_pkg::PH_TAG;
                            end
                        end
                        snpd_pkg::PH_COPYOFF: begin
                            n_acc  = acc_new;
                            n_left = r_left - 3'd1;
                            if (r_left == 3'd1) begin
                                n_phase = snpd_pkg::PH_TAG;
                                n_state = snpd_pkg::S_COPY_CHK;
                            end
                        end
                        default: n_phase = snpd_pkg::PH_TAG;
                    endcase
                end
            end
            snpd_pkg::S_COPY_CHK: begin
                if (off_bad) begin
                    // A bad offset gives one error item and drops the copy.
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = 8'd0;
                        n_out_last  = 1'b1;
                        n_out_done  = 1'b0;
                        n_out_bad   = 1'b1;
                        n_state     = snpd_pkg::S_PARSE;
                    end
                end else begin
                    n_copy_left = (32'(copy_len) > room) ? room[6:0] : copy_len;
                    n_state     = snpd_pkg::S_COPY_RD;
                end
            end
            snpd_pkg::S_COPY_RD: begin
                // The ring read is in flight; its data is registered.
                n_state = snpd_pkg::S_COPY_WR;
            end
            snpd_pkg::S_COPY_WR: begin
                // Write the copied byte back and emit it together.
                if (out_free) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    n_wp        = wp_inc;
                    n_bw        = r_bw + 32'd1;
                    n_copy_left = r_copy_left - 7'd1;
                    n_out_valid = 1'b1;
                    n_out_byte  = ram_rd_data;
                    n_out_last  = (r_copy_left == 7'd1);
                    n_out_done  = (r_copy_left == 7'd1) && bw_hits_len;
                    n_out_bad   = 1'b0;
                    n_state     = (r_copy_left == 7'd1) ? snpd_pkg::S_PARSE
                                                        : snpd_pkg::S_COPY_RD;
                end
            end
            default: n_state = snpd_pkg::S_PARSE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= snpd_pkg::S_PARSE;
            r_phase     <= snpd_pkg::PH_TAG;
            r_out_len   <= '0;
            r_wp        <= '0;
            r_bw        <= '0;
            r_tag       <= '0;
            r_acc       <= '0;
            r_left      <= '0;
            r_lit_rem   <= '0;
            r_copy_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_bw        <= n_bw;
            r_tag       <= n_tag;
            r_acc       <= n_acc;
            r_left      <= n_left;
            r_lit_rem   <= n_lit_rem;
            r_copy_left <= n_copy_left;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_out_len <= i_cfg_output_length;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_done <= n_out_done;
        r_out_bad  <= n_out_bad;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;
    assign o_stream_done = r_out_done;
    assign o_bad_offset  = r_out_bad;

    // A stalled copy write must not move the ring pointer.
    `SNPD_ASSERT_NEXT(a_copy_stall_holds_wp, (r_state == snpd_pkg::S_COPY_WR) && !out_free, $stable(r_wp))
    // The copy engine only reads while bytes remain.
    `SNPD_ASSERT_SAME(a_copy_rd_has_bytes, r_state == snpd_pkg::S_COPY_RD, r_copy_left != 7'd0)
    // An error item carries a zero byte, ends its run and never completes the stream.
    `SNPD_ASSERT_SAME(a_error_item_form, r_out_valid && r_out_bad, (r_out_byte == 8'd0) && r_out_last && !r_out_done)

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned WIN        = snpd_pkg::WINDOW_BYTES_DEF;
    localparam int unsigned LIMIT      = 500_000;
    localparam int unsigned SETTLE     = 16;
    localparam int unsigned TAIL       = 200;
    localparam int unsigned HOLD       = 400;
    localparam int unsigned RAND_ITEMS = 60;
    localparam logic [31:0] LEN_MAX    = 32'hFFFF_FFFF;

    // One decompressed item as the block should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       bad;
    } t_out_item;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_len   = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        out_done;
    logic        out_bad;

    // Shadow of the decompressor: history, parser and length register.
    logic [7:0]       hist [WIN];
    int unsigned      wr_ptr;
    logic [31:0]      n_written;
    snpd_pkg::t_phase phase;
    logic [7:0]       tag_r;
    logic [31:0]      acc;
    logic [2:0]       left;
    logic [32:0]      lit_left;
    logic [31:0]      len_cfg;
    t_out_item        expected_q[$];

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned copies_sent  = 0;
    int unsigned bad_cnt      = 0;
    int unsigned fail_cnt     = 0;
    int unsigned cycle_cnt    = 0;
    int unsigned rx_gap       = 0;
    logic        idle_on      = 1'b1;
    logic        rx_hold      = 1'b0;
    bit          tx_offering  = 1'b0;

    always #5 clk = ~clk;

    snappy_stream_decompressor_top dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_output_length (cfg_len),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_in_byte           (in_byte),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_out_byte          (out_byte),
        .o_last_of_run       (out_last),
        .o_stream_done       (out_done),
        .o_bad_offset        (out_bad)
    );

    // Counts failures and reports only the first ten of them.
    task automatic note_fail(input string what);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Length or offset bytes that follow a given tag.
    function automatic logic [2:0] hdr_len(input logic [7:0] t);
        if (t[1:0] == snpd_pkg::KIND_LITERAL) begin
            return (t[7:2] < snpd_pkg::LIT_EXT_FIRST) ? 3'd0
                 : 3'(t[7:2] - snpd_pkg::LIT_EXT_FIRST + 6'd1);
        end
        if (t[1:0] == snpd_pkg::KIND_COPY1) return 3'd1;
        if (t[1:0] == snpd_pkg::KIND_COPY2) return 3'd2;
        return 3'd4;
    endfunction

    // Gathers one header byte, lowest byte first; true once the field is whole.
    function automatic bit take_hdr_byte(input logic [7:0] b);
        logic [1:0] pos;
        pos = 2'(hdr_len(tag_r) - left);
        acc = acc | (32'(b) << (8 * pos));
        if (left != 0) left = left - 3'd1;
        return left == 0;
    endfunction

    function automatic void hist_push(input logic [7:0] v);
        hist[wr_ptr] = v;
        wr_ptr = (wr_ptr + 1) % WIN;
        n_written++;
    endfunction

    // Advances the shadow by one accepted byte and queues what it produces.
    task automatic decode_byte(input logic [7:0] b);
        logic [31:0] ofs;
        logic [31:0] cnt;
        logic [31:0] room;
        logic [7:0]  v;
        int unsigned src;
        int unsigned i;
        if (n_written >= len_cfg) return;
        case (phase)
            snpd_pkg::PH_TAG: begin
                tag_r = b;
                acc   = '0;
                left  = hdr_len(b);
                if (b[1:0] == snpd_pkg::KIND_LITERAL && left == 0) begin
                    lit_left = 33'(b[7:2]) + 33'd1;
                    phase    = snpd_pkg::PH_LITDATA;
                end else if (b[1:0] == snpd_pkg::KIND_LITERAL) begin
                    phase = snpd_pkg::PH_LITLEN;
                end else begin
                    phase = snpd_pkg::PH_COPYOFF;
                end
            end
            snpd_pkg::PH_LITLEN: begin
                if (take_hdr_byte(b)) begin
                    lit_left = {1'b0, acc} + 33'd1;
                    phase    = snpd_pkg::PH_LITDATA;
                end
            end
            snpd_pkg::PH_LITDATA: begin
                hist_push(b);
                lit_left = lit_left - 33'd1;
                if (lit_left == 0) phase = snpd_pkg::PH_TAG;
                expected_q.push_back(t_out_item'{b, 1'b1, n_written == len_cfg, 1'b0});
            end
            snpd_pkg::PH_COPYOFF: begin
                if (take_hdr_byte(b)) begin
                    phase = snpd_pkg::PH_TAG;
                    if (tag_r[1:0] == snpd_pkg::KIND_COPY1) begin
                        ofs = {21'd0, tag_r[7:5], acc[7:0]};
                        cnt = 32'(tag_r[4:2]) + 32'd4;
                    end else begin
                        ofs = acc;
                        cnt = 32'(tag_r[7:2]) + 32'd1;
                    end
                    if (ofs == 0 || ofs > n_written || ofs > 32'(WIN)) begin
                        bad_cnt++;
                        expected_q.push_back(t_out_item'{8'h00, 1'b1, 1'b0, 1'b1});
                    end else begin
                        room = len_cfg - n_written;
                        if (cnt > room) cnt = room;
                        // Each byte lands in the history before the next is read.
                        for (i = 0; i < cnt; i++) begin
                            src = (wr_ptr + WIN - ofs) % WIN;
                            v   = hist[src];
                            hist_push(v);
                            expected_q.push_back(t_out_item'{v, (i + 1 == cnt),
                                (i + 1 == cnt) && (n_written == len_cfg), 1'b0});
                        end
                    end
                end
            end
            default: phase = snpd_pkg::PH_TAG;
        endcase
    endtask

    // Lowers the input valid; the edge wait keeps a later raise out of this step.
    task automatic stop_offering();
        if (tx_offering) begin
            in_valid <= 1'b0;
            tx_offering = 1'b0;
            @(posedge clk);
        end
    endtask

    // Offers one byte, with an occasional idle burst ahead of it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            stop_offering();
            repeat (gap - 1) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        tx_offering = 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        decode_byte(b);
    endtask

    task automatic wait_drained();
        stop_offering();
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    // Length register write, only once the block has gone quiet.
    task automatic write_len(input logic [31:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_len   <= value;
        do @(posedge clk); while (!cfg_ready);
        len_cfg = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Literal of len random bytes; nlen length bytes, or an inline length when 0.
    task automatic send_literal(input int unsigned len, input int unsigned nlen);
        logic [31:0] code;
        int unsigned k;
        code = len - 1;
        if (nlen == 0) begin
            send_byte({code[5:0], snpd_pkg::KIND_LITERAL});
        end else begin
            send_byte({6'(snpd_pkg::LIT_EXT_FIRST + 6'(nlen) - 6'd1),
                       snpd_pkg::KIND_LITERAL});
            for (k = 0; k < nlen; k++) send_byte(code[8 * k +: 8]);
        end
        for (k = 0; k < len; k++) send_byte(8'($urandom));
    endtask

    task automatic send_copy(input logic [1:0] kind, input logic [31:0] ofs,
                             input int unsigned len);
        logic [5:0]  lc;
        int unsigned k;
        lc = 6'(len - 1);
        copies_sent++;
        case (kind)
            snpd_pkg::KIND_COPY1: begin
                send_byte({ofs[10:8], 3'(len - 4), snpd_pkg::KIND_COPY1});
                send_byte(ofs[7:0]);
            end
            snpd_pkg::KIND_COPY2: begin
                send_byte({lc, snpd_pkg::KIND_COPY2});
                send_byte(ofs[7:0]);
                send_byte(ofs[15:8]);
            end
            default: begin
                send_byte({lc, snpd_pkg::KIND_COPY4});
                for (k = 0; k < 4; k++) send_byte(ofs[8 * k +: 8]);
            end
        endcase
    endtask

    function automatic int unsigned copy_len(input logic [1:0] kind);
        if (kind == snpd_pkg::KIND_COPY1) return $urandom_range(4, 11);
        return ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
    endfunction

    // With a zero length every item is dropped, from reset and after a write.
    task automatic test_length_zero();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        write_len(32'd0);
        send_byte(8'h3C);
        send_byte(8'h80);
    endtask

    // Inline literal, then each width of length field.
    task automatic test_literals();
        write_len(LEN_MAX);
        send_byte({6'd1, snpd_pkg::KIND_LITERAL});
        send_byte(8'h00);
        send_byte(8'hFF);
        send_literal(1, 1);
        send_literal(2, 2);
        send_literal(1, 3);
        send_literal(3, 4);
    endtask

    // All copy kinds, overlapping runs and the oldest byte held.
    task automatic test_copies();
        send_copy(snpd_pkg::KIND_COPY1, 32'd1, 4);
        send_copy(snpd_pkg::KIND_COPY1, n_written, 11);
        send_copy(snpd_pkg::KIND_COPY2, 32'd3, 64);
        send_copy(snpd_pkg::KIND_COPY2, 32'd1, 1);
        send_copy(snpd_pkg::KIND_COPY4, 32'd2, 5);
    endtask

    // Zero offset, one past the history, and the largest offset there is.
    task automatic test_bad_offsets();
        send_copy(snpd_pkg::KIND_COPY1, 32'd0, 4);
        send_copy(snpd_pkg::KIND_COPY2, n_written + 1, 1);
        send_copy(snpd_pkg::KIND_COPY4, 32'hFFFF_FFFF, 64);
    endtask

    // Copies and literals cut short at the length, and items dropped after it.
    task automatic test_length_cut();
        write_len(n_written + 5);
        send_copy(snpd_pkg::KIND_COPY2, 32'd1, 10);
        send_byte(8'hFF);
        write_len(n_written + 3);
        send_byte({6'd5, snpd_pkg::KIND_LITERAL});
        repeat (5) send_byte(8'($urandom));
        // A length below what has been written keeps the stream complete.
        write_len(32'd1);
        repeat (2) send_byte(8'($urandom));
        write_len(LEN_MAX);
        repeat (3) send_byte(8'($urandom));
    endtask

    // Receiver holds off while long copies queue up behind it.
    task automatic test_backpressure();
        rx_hold <= 1'b1;
        fork
            begin
                repeat (HOLD) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (6) send_copy(snpd_pkg::KIND_COPY2, $urandom_range(1, n_written), 64);
        wait_drained();
    endtask

    // Mostly well-formed elements with random content, some broken copies.
    task automatic test_random();
        int unsigned start;
        int unsigned r;
        int unsigned lim;
        int unsigned len;
        logic [1:0]  kind;
        logic [31:0] ofs;
        start = items_sent;
        send_literal(16, 0);
        while (items_sent - start < RAND_ITEMS) begin
            if ($urandom_range(0, 19) == 0) idle_on <= ~idle_on;
            r = $urandom_range(0, 99);
            if (r < 35 || n_written == 0) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60)
                                                  : $urandom_range(1, 8);
                send_literal(len, $urandom_range(0, 4));
            end else begin
                kind = 2'($urandom_range(1, 3));
                if (r < 85) begin
                    lim = (kind == snpd_pkg::KIND_COPY1) ? 2047
                        : (kind == snpd_pkg::KIND_COPY2) ? 65535 : WIN;
                    if (lim > n_written) lim = n_written;
                    ofs = $urandom_range(1, lim);
                end else begin
                    ofs = $urandom_range(0, 1) ? 32'd0 : n_written + $urandom_range(1, 200);
                    if (kind == snpd_pkg::KIND_COPY1 && ofs > 2047) ofs = 32'd0;
                end
                send_copy(kind, ofs, copy_len(kind));
            end
        end
        idle_on <= 1'b1;
        wait_drained();
    endtask

    // Items and results back to back, with no idling on either side.
    task automatic test_back_to_back();
        idle_on <= 1'b0;
        send_literal(8, 0);
        send_copy(snpd_pkg::KIND_COPY2, $urandom_range(1, n_written), 16);
        send_copy(snpd_pkg::KIND_COPY1, 32'd3, 6);
        send_literal(4, 1);
    endtask

    // Largest four-byte literal length, stopped by the length register.
    task automatic test_huge_literal();
        write_len(n_written + 3);
        send_byte({6'(snpd_pkg::LIT_EXT_FIRST + 6'd3), snpd_pkg::KIND_LITERAL});
        repeat (4) send_byte(8'hFF);
        repeat (5) send_byte(8'($urandom));
        write_len(32'd0);
        repeat (2) send_byte(8'($urandom));
    endtask

    // Receiver ready: random stall bursts, or a long hold-off when asked.
    always @(posedge clk) begin
        if (rx_hold) begin
            out_ready <= 1'b0;
        end else if (!idle_on) begin
            out_ready <= 1'b1;
        end else if (rx_gap != 0) begin
            out_ready <= 1'b0;
            rx_gap    <= rx_gap - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            rx_gap    <= $urandom_range(0, 13);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Each accepted result against the oldest expected item.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                note_fail($sformatf("result byte %02h with nothing expected", out_byte));
            end else begin
                want = expected_q.pop_front();
                if (want.data !== out_byte || want.last !== out_last ||
                    want.done !== out_done || want.bad !== out_bad) begin
                    note_fail($sformatf({"expected byte %02h last %0b done %0b bad %0b, ",
                        "got byte %02h last %0b done %0b bad %0b"},
                        want.data, want.last, want.done, want.bad,
                        out_byte, out_last, out_done, out_bad));
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Timed out after %0d cycles with %0d items outstanding.",
                     cycle_cnt, expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        wr_ptr    = 0;
        n_written = '0;
        phase     = snpd_pkg::PH_TAG;
        tag_r     = '0;
        acc       = '0;
        left      = '0;
        lit_left  = '0;
        len_cfg   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_length_zero();
        test_literals();
        test_copies();
        test_bad_offsets();
        test_length_cut();
        test_backpressure();
        test_random();
        test_back_to_back();
        test_huge_literal();
        wait_drained();
        repeat (TAIL) @(posedge clk);
        $display("Sent %0d compressed bytes (%0d copies) and checked %0d output items.",
                 items_sent, copies_sent, results_seen);
        $display("Of those, %0d were bad-offset items; the history held %0d bytes at the end.",
                 bad_cnt, n_written);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
